@@ sv/ubs_pkg.sv @@
// shared constants, state encodings and command/status structs for the
// upper-triangular back substitution block; no dependencies
package ubs_pkg;

	localparam int MAX_SIZE_DEF = 8;
	localparam int SIZE_W = 4;
	localparam int VAL_W = 32;
	localparam int ACC_W = 64;
	localparam int FRAC_W = 16;
	localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW,
		ST_DIAG,
		ST_MUL,
		ST_ACC,
		ST_NUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_WRITE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PREP,
		DV_ITER,
		DV_DONE
	} div_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_acc;
		logic cap_diag;
		logic mul;
		logic acc;
		logic num;
		logic div_start;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic diag_zero;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

@@ sv/ubs_chan_if.sv @@
// request and result channel interfaces (valid/ready with payload)
// depends on ubs_pkg for field widths
interface ubs_req_if import ubs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    is_rhs;
	logic [2:0]              row;
	logic [2:0]              col;
	logic signed [VAL_W-1:0] value;
	logic                    start_solve;

	modport source (output valid, is_rhs, row, col, value, start_solve, input ready);
	modport sink (input valid, is_rhs, row, col, value, start_solve, output ready);
endinterface

interface ubs_res_if import ubs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              unknown_index;
	logic signed [VAL_W-1:0] unknown_value;
	logic                    zero_pivot;
	logic                    saturated;
	logic                    last;

	modport source (output valid, unknown_index, unknown_value, zero_pivot, saturated, last,
		input ready);
	modport sink (input valid, unknown_index, unknown_value, zero_pivot, saturated, last,
		output ready);
endinterface

@@ sv/ubs_div.sv @@
// iterative signed divider, Q32.32 by Q16.16 giving a clamped Q16.16 quotient
// one quotient bit per cycle; depends on ubs_pkg
module ubs_div import ubs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [VAL_W-1:0] den,
	output logic                    done,
	output logic signed [VAL_W-1:0] quot,
	output logic                    ovf
);

	localparam int HALF_W = ACC_W - VAL_W;
	localparam int CNT_W = $clog2(VAL_W);

	div_state_t        state_q, state_d;
	logic [ACC_W-1:0]  nm_q;
	logic [VAL_W-1:0]  dm_q;
	logic              neg_q;
	logic              big_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  low_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [ACC_W-1:0]  nm_d;
	logic [VAL_W-1:0]  dm_d;
	logic              big_d;
	logic [VAL_W:0]    rem_sh;
	logic [VAL_W:0]    diff;
	logic              ge;

	// magnitudes at start
	assign nm_d = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
	assign dm_d = den[VAL_W-1] ? (~den + VAL_W'(1)) : den;

	// quotient of 2^32 or more cannot fit
	assign big_d = nm_q[ACC_W-1 -: HALF_W] >= HALF_W'(dm_q);

	// restoring step
	assign rem_sh = {rem_q, low_q[VAL_W-1]};
	assign diff = rem_sh - {1'b0, dm_q};
	assign ge = rem_sh >= {1'b0, dm_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE, DV_DONE: begin
				if (start) state_d = DV_PREP;
			end
			DV_PREP: begin
				state_d = big_d ? DV_DONE : DV_ITER;
			end
			DV_ITER: begin
				if (cnt_q == '0) state_d = DV_DONE;
			end
			default: state_d = DV_IDLE;
		endcase
	end

	// sign and clamp of the result
	always_comb begin
		done = (state_q == DV_DONE);
		ovf = 1'b0;
		quot = $signed(low_q);
		if (big_q) begin
			ovf = 1'b1;
			quot = neg_q ? $signed({1'b1, {(VAL_W-1){1'b0}}}) : $signed({1'b0, {(VAL_W-1){1'b1}}});
		end else if (neg_q) begin
			if (low_q > {1'b1, {(VAL_W-1){1'b0}}}) begin
				ovf = 1'b1;
				quot = $signed({1'b1, {(VAL_W-1){1'b0}}});
			end else begin
				quot = $signed(~low_q + VAL_W'(1));
			end
		end else if (low_q[VAL_W-1]) begin
			ovf = 1'b1;
			quot = $signed({1'b0, {(VAL_W-1){1'b1}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// operand and iteration registers
	always_ff @(posedge clk) begin
		if ((state_q == DV_IDLE || state_q == DV_DONE) && start) begin
			nm_q <= nm_d;
			dm_q <= dm_d;
			neg_q <= num[ACC_W-1] ^ den[VAL_W-1];
			big_q <= 1'b0;
		end else if (state_q == DV_PREP) begin
			big_q <= big_d;
			rem_q <= nm_q[ACC_W-1 -: HALF_W];
			low_q <= nm_q[VAL_W-1:0];
			cnt_q <= CNT_W'(VAL_W - 1);
		end else if (state_q == DV_ITER) begin
			rem_q <= ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
			low_q <= {low_q[VAL_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// partial remainder stays below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DV_ITER |-> rem_q < dm_q)
		else $error("divider remainder not below divisor");

endmodule

@@ sv/ubs_datapath.sv @@
// coefficient, right-hand side and solution stores, multiply-accumulate,
// numerator, divider and result register; depends on ubs_pkg and ubs_div
module ubs_datapath import ubs_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	input  logic [IDX_W-1:0]        row_idx,
	input  logic [IDX_W-1:0]        col_idx,
	input  logic                    ld_is_rhs,
	input  logic [2:0]              ld_row,
	input  logic [2:0]              ld_col,
	input  logic signed [VAL_W-1:0] ld_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              out_index,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    out_zero_pivot,
	output logic                    out_saturated,
	output logic                    out_last
);

	localparam int CDEPTH = 2 ** (2 * IDX_W);
	localparam int RDEPTH = 2 ** IDX_W;

	logic signed [VAL_W-1:0] coeff_mem [0:CDEPTH-1];
	logic signed [VAL_W-1:0] rhs_mem [0:RDEPTH-1];
	logic signed [VAL_W-1:0] sol_mem [0:RDEPTH-1];

	logic signed [VAL_W-1:0] coeff_rd_q, rhs_rd_q, sol_rd_q;
	logic signed [VAL_W-1:0] diag_q, rhs_q;
	logic signed [ACC_W-1:0] prod_q, acc_q, num_q;
	logic                    sat_q;
	logic                    valid_q;

	logic                    ld_row_ok, ld_col_ok;
	logic [IDX_W-1:0]        ld_r, ld_c;
	logic [ACC_W:0]          add_res, sub_res;
	logic signed [ACC_W-1:0] rhs_ext;
	logic                    div_done, div_ovf;
	logic signed [VAL_W-1:0] div_quot;
	logic                    diag_zero;
	logic signed [VAL_W-1:0] res_value;
	logic                    res_sat;

	// saturating 64-bit add or subtract, flag in the top bit
	function automatic logic [ACC_W:0] sat_sum(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b, input logic sub);
		logic [ACC_W:0] s;
		s = sub ? ({a[ACC_W-1], a} - {b[ACC_W-1], b}) : ({a[ACC_W-1], a} + {b[ACC_W-1], b});
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {2'b11, {(ACC_W-1){1'b0}}} : {2'b10, {(ACC_W-1){1'b1}}};
		end
		return {1'b0, s[ACC_W-1:0]};
	endfunction

	// load address decode
	assign ld_row_ok = int'(ld_row) < MAX_SIZE;
	assign ld_col_ok = int'(ld_col) < MAX_SIZE;
	assign ld_r = IDX_W'(ld_row);
	assign ld_c = IDX_W'(ld_col);

	// stores, written on load or emit, read with registered data
	always_ff @(posedge clk) begin
		if (cmd.load && !ld_is_rhs && ld_row_ok && ld_col_ok) begin
			coeff_mem[{ld_r, ld_c}] <= ld_value;
		end
		if (cmd.load && ld_is_rhs && ld_row_ok) begin
			rhs_mem[ld_r] <= ld_value;
		end
		if (cmd.emit) begin
			sol_mem[row_idx] <= res_value;
		end
		coeff_rd_q <= coeff_mem[{row_idx, col_idx}];
		rhs_rd_q <= rhs_mem[row_idx];
		sol_rd_q <= sol_mem[col_idx];
	end

	// accumulate and numerator arithmetic
	assign add_res = sat_sum(acc_q, prod_q, 1'b0);
	assign rhs_ext = {{(ACC_W-VAL_W-FRAC_W){rhs_q[VAL_W-1]}}, rhs_q, {FRAC_W{1'b0}}};
	assign sub_res = sat_sum(rhs_ext, acc_q, 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.cap_diag) begin
			diag_q <= coeff_rd_q;
			rhs_q <= rhs_rd_q;
		end
		if (cmd.mul) begin
			prod_q <= ACC_W'(coeff_rd_q) * ACC_W'(sol_rd_q);
		end
		if (cmd.clr_acc) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.acc) begin
			acc_q <= $signed(add_res[ACC_W-1:0]);
			sat_q <= sat_q | add_res[ACC_W];
		end else if (cmd.num) begin
			num_q <= $signed(sub_res[ACC_W-1:0]);
			sat_q <= sat_q | sub_res[ACC_W];
		end
	end

	ubs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (diag_q),
		.done   (div_done),
		.quot   (div_quot),
		.ovf    (div_ovf)
	);

	// result selection
	assign diag_zero = (diag_q == '0);
	assign res_value = diag_zero ? '0 : div_quot;
	assign res_sat = sat_q | (!diag_zero & div_ovf);

	assign stat.diag_zero = diag_zero;
	assign stat.div_done = div_done;
	assign stat.out_free = !valid_q || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index <= 3'(row_idx);
			out_value <= res_value;
			out_zero_pivot <= diag_zero;
			out_saturated <= res_sat;
			out_last <= (row_idx == '0);
		end
	end

	assign out_valid = valid_q;

	// a zero pivot always reports a zero unknown
	a_zero_pivot_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_zero_pivot |-> out_value == '0)
		else $error("zero pivot result with nonzero value");

endmodule

@@ sv/ubs_ctrl.sv @@
// solve sequencer: size register, load acceptance, row and column counters
// and datapath commands; depends on ubs_pkg
module ubs_ctrl import ubs_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
	localparam int CNT_W = $clog2(MAX_SIZE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              req_valid,
	input  logic              req_start,
	output logic              req_ready,
	output cmd_t              cmd,
	input  stat_t             stat,
	output logic [IDX_W-1:0]  row_idx,
	output logic [IDX_W-1:0]  col_idx
);

	ctrl_state_t       state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  n_clamp;
	logic              accept;

	// size in use, clamped to 1..MAX_SIZE
	always_comb begin
		if (size_q == '0) begin
			n_clamp = CNT_W'(1);
		end else if (int'(size_q) > MAX_SIZE) begin
			n_clamp = CNT_W'(MAX_SIZE);
		end else begin
			n_clamp = CNT_W'(size_q);
		end
	end

	assign accept = req_valid && req_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_start) state_d = ST_ROW;
			end
			ST_ROW: state_d = ST_DIAG;
			ST_DIAG, ST_ACC: begin
				state_d = (j_q < n_q) ? ST_MUL : ST_NUM;
			end
			ST_MUL: state_d = ST_ACC;
			ST_NUM: begin
				state_d = stat.diag_zero ? ST_WRITE : ST_DIV_GO;
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (stat.div_done) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (stat.out_free) state_d = (i_q == '0) ? ST_IDLE : ST_ROW;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		req_ready = (state_q == ST_IDLE);
		cmd.load = accept;
		row_idx = i_q;
		col_idx = j_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: ;
			ST_ROW: begin
				cmd.clr_acc = 1'b1;
				col_idx = i_q;
			end
			ST_DIAG: cmd.cap_diag = 1'b1;
			ST_MUL: cmd.mul = 1'b1;
			ST_ACC: cmd.acc = 1'b1;
			ST_NUM: cmd.num = 1'b1;
			ST_DIV_GO: cmd.div_start = 1'b1;
			ST_DIV_WAIT: ;
			ST_WRITE: cmd.emit = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q <= SIZE_RST;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			// counters: rows walk down, columns walk up past the diagonal
			if (accept && req_start) begin
				n_q <= n_clamp;
				i_q <= IDX_W'(n_clamp - CNT_W'(1));
			end else if (state_q == ST_ROW) begin
				j_q <= CNT_W'(i_q) + CNT_W'(1);
			end else if (state_q == ST_MUL) begin
				j_q <= j_q + CNT_W'(1);
			end else if (state_q == ST_WRITE && stat.out_free && i_q != '0) begin
				i_q <= i_q - IDX_W'(1);
			end
		end
	end

	// a product term is always right of the diagonal and inside the system
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> (j_q < n_q) && (CNT_W'(i_q) < j_q))
		else $error("product term column out of range");

	// the active row stays inside the system
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> CNT_W'(i_q) < n_q)
		else $error("active row out of range");

endmodule

@@ sv/upper_triangular_back_substitution.sv @@
// top level of the upper-triangular back substitution solver
// depends on ubs_pkg, ubs_chan_if, ubs_ctrl, ubs_datapath
//
//  channel  dir  handshake       payload
//  cfg      in   cfg_we          cfg_wdata: system_size
//  req      in   valid / ready   is_rhs, row, col, value, start_solve
//  res      out  valid / ready   unknown_index, unknown_value, zero_pivot, saturated, last
//
// the request flagged start_solve starts the solve
// each unknown steps through row setup, diagonal capture, a multiply and an accumulate per term
// to its right, the numerator and the bit-serial divider (cut short when the quotient is 2^32 or
// more, skipped on a zero pivot), then goes into the result register
// requests are refused while a solve runs; a stalled result holds the solve at that row
// arst_n clears the controller, the size register (to 8) and the result valid flag;
// the stores are not cleared
module upper_triangular_back_substitution import ubs_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	ubs_req_if.sink           req,
	ubs_res_if.source         res
);

	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	cmd_t             cmd;
	stat_t            stat;
	logic [IDX_W-1:0] row_idx;
	logic [IDX_W-1:0] col_idx;

	// sequencer
	ubs_ctrl #(
		.MAX_SIZE (MAX_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req.valid),
		.req_start (req.start_solve),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat),
		.row_idx   (row_idx),
		.col_idx   (col_idx)
	);

	// stores and arithmetic
	ubs_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.row_idx        (row_idx),
		.col_idx        (col_idx),
		.ld_is_rhs      (req.is_rhs),
		.ld_row         (req.row),
		.ld_col         (req.col),
		.ld_value       (req.value),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.out_index      (res.unknown_index),
		.out_value      (res.unknown_value),
		.out_zero_pivot (res.zero_pivot),
		.out_saturated  (res.saturated),
		.out_last       (res.last)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for upper_triangular_back_substitution: loads random and corner-case
// triangular systems, predicts each solved unknown and checks it field by field
// depends on ubs_pkg, ubs_req_if / ubs_res_if and the solver rtl
module tb_top import ubs_pkg::*; ();

	localparam int DIM = MAX_SIZE_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [VAL_W-1:0] CORNER_VALUES [7] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
		32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000
	};

	// one load request
	typedef struct {
		bit               is_rhs;
		bit [2:0]         row;
		bit [2:0]         col;
		logic [VAL_W-1:0] value;
		bit               start;
	} load_t;

	// one solved unknown
	typedef struct packed {
		logic [2:0]       idx;
		logic [VAL_W-1:0] val;
		logic             zp;
		logic             sat;
		logic             last;
	} unknown_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	ubs_req_if req_ch ();
	ubs_res_if res_ch ();

	upper_triangular_back_substitution #(.MAX_SIZE(DIM)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch)
	);

	// solver image kept by the testbench
	int                coef_mem [DIM*DIM];
	int                rhs_mem [DIM];
	int                soln_mem [DIM];
	bit                coef_written [DIM*DIM];
	bit                rhs_written [DIM];
	logic [SIZE_W-1:0] size_cfg = SIZE_RST;

	unknown_t expected_unknowns [$];
	int       mismatches = 0;
	int       loads_sent = 0;
	int       max_req_gap = 5;
	int       max_res_stall = 5;
	int       quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	function automatic int active_size();
		if (size_cfg == 0)
			return 1;
		if (size_cfg > DIM)
			return DIM;
		return int'(size_cfg);
	endfunction

	function automatic longint add_clamped(longint a, longint b, inout bit ovf);
		longint sum;
		sum = a + b;
		if (a[63] == b[63] && sum[63] != a[63]) begin
			ovf = 1'b1;
			return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return sum;
	endfunction

	function automatic longint sub_clamped(longint a, longint b, inout bit ovf);
		longint diff;
		diff = a - b;
		if (a[63] != b[63] && diff[63] != a[63]) begin
			ovf = 1'b1;
			return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return diff;
	endfunction

	// Q32.32 over Q16.16, truncated toward zero, clamped to 32 bits
	function automatic logic [VAL_W-1:0] divide_q16(longint num, int den, inout bit ovf);
		longint unsigned nm;
		longint unsigned dm;
		longint unsigned q;
		longint unsigned neg_q;
		nm = num[63] ? 64'(-num) : 64'(num);
		dm = den[31] ? 64'(-longint'(den)) : 64'(longint'(den));
		q = nm / dm;
		if (num[63] ^ den[31]) begin
			if (q > 64'h8000_0000) begin
				ovf = 1'b1;
				return 32'h8000_0000;
			end
			neg_q = 64'd0 - q;
			return neg_q[31:0];
		end
		if (q > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	// back substitution from the last row upward, queuing each unknown
	function automatic void solve_unknowns();
		int               n;
		int               i;
		int               j;
		longint           acc;
		longint           numer;
		bit               sat;
		bit               zp;
		logic [VAL_W-1:0] x;
		n = active_size();
		for (i = n - 1; i >= 0; i--) begin
			sat = 1'b0;
			acc = 0;
			for (j = i + 1; j < n; j++)
				acc = add_clamped(acc, longint'(coef_mem[i*DIM+j]) * longint'(soln_mem[j]), sat);
			numer = sub_clamped(longint'(rhs_mem[i]) * 65536, acc, sat);
			if (coef_mem[i*DIM+i] == 0) begin
				zp = 1'b1;
				x = '0;
			end else begin
				zp = 1'b0;
				x = divide_q16(numer, coef_mem[i*DIM+i], sat);
			end
			soln_mem[i] = int'(x);
			expected_unknowns.push_back('{3'(i), x, zp, sat, i == 0});
		end
	endfunction

	function automatic logic [VAL_W-1:0] pick_value(bit on_diag);
		int               r;
		logic [VAL_W-1:0] mag;
		r = $urandom_range(0, 99);
		if (r < 5)
			return CORNER_VALUES[$urandom_range(0, 6)];
		if (on_diag) begin
			if (r < 10)
				return '0;
			mag = $urandom_range(32'h4000, 32'h4_0000);
		end else begin
			if (r < 12)
				return $urandom;
			mag = $urandom_range(0, 32'h4_0000);
		end
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// drive one request and wait for it to be taken; valid stays high on return
	task automatic send_load(load_t ld);
		int gap;
		gap = $urandom_range(0, max_req_gap);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.is_rhs <= ld.is_rhs;
		req_ch.row <= ld.row;
		req_ch.col <= ld.col;
		req_ch.value <= ld.value;
		req_ch.start_solve <= ld.start;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		loads_sent++;
		// store first, then the solve sees the entry
		if (ld.is_rhs) begin
			rhs_mem[ld.row] = int'(ld.value);
			rhs_written[ld.row] = 1'b1;
		end else begin
			coef_mem[ld.row*DIM+ld.col] = int'(ld.value);
			coef_written[ld.row*DIM+ld.col] = 1'b1;
		end
		if (ld.start)
			solve_unknowns();
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_unknowns.size() != 0);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] val);
		wait_results_drained();
		// let the controller settle back to idle after the last result
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_cfg = val;
	endtask

	// load a system for the active size in random order, last request starts the solve
	task automatic run_system(bit rewrite_all);
		load_t items [$];
		load_t ld;
		load_t tmp;
		int    n;
		int    k;
		int    pick;
		n = active_size();
		for (int r = 0; r < n; r++) begin
			if (rewrite_all || !rhs_written[r] || $urandom_range(0, 3) == 0) begin
				ld = '{1'b1, 3'(r), 3'($urandom), pick_value(1'b0), 1'b0};
				items.push_back(ld);
			end
			for (int c = r; c < n; c++) begin
				if (rewrite_all || !coef_written[r*DIM+c] || $urandom_range(0, 3) == 0) begin
					ld = '{1'b0, 3'(r), 3'(c), pick_value(c == r), 1'b0};
					items.push_back(ld);
				end
			end
		end
		// entries anywhere, including below the diagonal and past the size
		repeat ($urandom_range(0, 3)) begin
			ld.is_rhs = $urandom_range(0, 1);
			ld.row = $urandom;
			ld.col = $urandom;
			ld.value = pick_value(ld.row == ld.col);
			ld.start = 1'b0;
			items.push_back(ld);
		end
		if (items.size() == 0) begin
			ld = '{1'b1, 3'($urandom_range(0, n - 1)), 3'($urandom), pick_value(1'b0), 1'b0};
			items.push_back(ld);
		end
		for (k = items.size() - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			tmp = items[k];
			items[k] = items[pick];
			items[pick] = tmp;
		end
		items[items.size()-1].start = 1'b1;
		foreach (items[m])
			send_load(items[m]);
	endtask

	// saturation of quotient, sum and numerator, zero pivot, start on each kind of entry
	task automatic test_directed();
		write_size(4'd2);
		send_load('{1'b0, 3'd0, 3'd0, 32'h0001_0000, 1'b0});
		send_load('{1'b0, 3'd0, 3'd1, 32'h7FFF_FFFF, 1'b0});
		send_load('{1'b0, 3'd1, 3'd1, 32'h0000_0001, 1'b0});
		send_load('{1'b1, 3'd1, 3'd7, 32'h7FFF_FFFF, 1'b0});
		send_load('{1'b0, 3'd1, 3'd0, 32'hFFFF_FFFF, 1'b0});
		send_load('{1'b1, 3'd0, 3'd0, 32'h8000_0000, 1'b1});
		write_size(4'd3);
		send_load('{1'b0, 3'd0, 3'd0, 32'h0000_0000, 1'b0});
		send_load('{1'b0, 3'd0, 3'd1, 32'h8000_0000, 1'b0});
		send_load('{1'b0, 3'd0, 3'd2, 32'h8000_0000, 1'b0});
		send_load('{1'b0, 3'd1, 3'd1, 32'h0000_0001, 1'b0});
		send_load('{1'b0, 3'd1, 3'd2, 32'h0000_0000, 1'b0});
		send_load('{1'b0, 3'd2, 3'd2, 32'h0000_0001, 1'b0});
		send_load('{1'b1, 3'd2, 3'd0, 32'h8000_0000, 1'b0});
		send_load('{1'b1, 3'd1, 3'd0, 32'h8000_0000, 1'b0});
		send_load('{1'b1, 3'd0, 3'd0, 32'h8000_0000, 1'b0});
		send_load('{1'b0, 3'd2, 3'd1, 32'h1234_5678, 1'b1});
		write_size(4'd1);
		send_load('{1'b0, 3'd0, 3'd0, 32'hFFFE_8000, 1'b0});
		send_load('{1'b1, 3'd0, 3'd5, 32'h0003_0000, 1'b1});
		send_load('{1'b1, 3'd0, 3'd2, 32'hAAAA_AAAA, 1'b0});
		send_load('{1'b0, 3'd0, 3'd0, 32'h5555_5555, 1'b1});
	endtask

	// size register outside 1..8 and at both ends
	task automatic test_size_limits();
		write_size(4'd0);
		run_system(1'b1);
		write_size(4'd15);
		run_system(1'b1);
		write_size(4'd9);
		run_system(1'b0);
		write_size(4'd8);
		run_system(1'b0);
	endtask

	// no idling on either side, then the sender holds off until all results are in
	task automatic test_back_to_back();
		max_req_gap = 0;
		max_res_stall = 0;
		write_size(4'($urandom_range(1, DIM)));
		repeat (3)
			run_system(1'b0);
		wait_results_drained();
		run_system(1'b0);
		max_req_gap = 5;
		max_res_stall = 5;
		run_system(1'b0);
		wait_results_drained();
		run_system(1'b1);
	endtask

	// random sizes, contents and idling until the request budget is spent
	task automatic test_random_systems();
		int target;
		int r;
		target = 260;
		while (loads_sent < target) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				write_size(4'd0);
			else if (r == 1)
				write_size(4'($urandom_range(DIM + 1, 15)));
			else
				write_size(4'($urandom_range(1, DIM)));
			max_req_gap = $urandom_range(0, 3) == 0 ? 0 : 5;
			max_res_stall = $urandom_range(0, 3) == 0 ? 0 : 5;
			repeat ($urandom_range(1, 4)) begin
				run_system($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0)
					wait_results_drained();
			end
		end
	endtask

	// result side: random stalls, compare against the oldest prediction
	initial begin : result_checker
		unknown_t want;
		int       stall;
		res_ch.ready <= 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, max_res_stall);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			if (expected_unknowns.size() == 0) begin
				report_mismatch("unrequested result index", 32'(res_ch.unknown_index), '0);
			end else begin
				want = expected_unknowns.pop_front();
				if (res_ch.unknown_index !== want.idx)
					report_mismatch("unknown_index", 32'(res_ch.unknown_index), 32'(want.idx));
				if (res_ch.unknown_value !== want.val)
					report_mismatch($sformatf("unknown_value x%0d", want.idx),
						res_ch.unknown_value, want.val);
				if (res_ch.zero_pivot !== want.zp)
					report_mismatch($sformatf("zero_pivot x%0d", want.idx),
						32'(res_ch.zero_pivot), 32'(want.zp));
				if (res_ch.saturated !== want.sat)
					report_mismatch($sformatf("saturated x%0d", want.idx),
						32'(res_ch.saturated), 32'(want.sat));
				if (res_ch.last !== want.last)
					report_mismatch($sformatf("last x%0d", want.idx),
						32'(res_ch.last), 32'(want.last));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reset, test sequence and final verdict
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.is_rhs <= 1'b0;
		req_ch.row <= '0;
		req_ch.col <= '0;
		req_ch.value <= '0;
		req_ch.start_solve <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_limits();
		test_back_to_back();
		test_random_systems();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
